// File: hw/rtl/rsd_pkg.sv
package rsd_pkg;

    localparam int COL_W   = 8;
    localparam int ROW_W   = 8;
    localparam int X_W     = 10;
    localparam int LEN_W   = 8;
    localparam int COLOR_W = 16;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 64;

    localparam logic [IDX_W-1:0] CFG_CLIP_OFFSET      = 3'd0;
    localparam logic [IDX_W-1:0] CFG_VISIBLE_WIDTH    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DEST_X           = 3'd2;
    localparam logic [IDX_W-1:0] CFG_PALETTE_LOW      = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PALETTE_MID_LOW  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_PALETTE_MID_HIGH = 3'd5;
    localparam logic [IDX_W-1:0] CFG_PALETTE_HIGH     = 3'd6;

    localparam logic [COL_W-1:0] VISIBLE_WIDTH_RESET = 8'd132;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
        logic push;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic more;
        logic hit;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/rsd_ctrl.sv
module rsd_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  rsd_pkg::status_t st,
    output rsd_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = RUN;
                end
            end
            RUN:
            begin
                if (!st.more)
                begin
                    state_next = FLUSH;
                end
                else if (!(st.hit && st.pend_valid && !st.out_free))
                begin
                    cmd.step    = 1'b1;
                    cmd.capture = st.hit;
                    cmd.push    = st.hit && st.pend_valid;
                end
            end
            FLUSH:
            begin
                if (!st.pend_valid)
                begin
                    state_next = IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.push   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/rsd_datapath.sv
module rsd_datapath
#(
    parameter int SPRITE_WIDTH  = 132,
    parameter int SPRITE_HEIGHT = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rsd_pkg::IDX_W-1:0]        cfg_index,
    input  logic [rsd_pkg::CFG_W-1:0]        cfg_data,
    input  logic [rsd_pkg::IN_W-1:0]         s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rsd_pkg::OUT_W-1:0]        m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser,
    input  rsd_pkg::cmd_t                    cmd,
    output rsd_pkg::status_t                 st
);

    localparam logic [8:0] WIDTH9  = 9'(SPRITE_WIDTH);
    localparam logic [8:0] HEIGHT9 = 9'(SPRITE_HEIGHT);

    logic [rsd_pkg::COL_W-1:0]   clip_offset_reg;
    logic [rsd_pkg::COL_W-1:0]   visible_width_reg;
    logic [rsd_pkg::X_W-1:0]     dest_x_reg;
    logic [rsd_pkg::CFG_W-1:0]   palette_reg [4];

    logic [rsd_pkg::COL_W-1:0]   col_reg;
    logic [rsd_pkg::ROW_W-1:0]   row_reg;
    logic                        fin_reg;
    logic [7:0]                  rem_reg;
    logic                        done_now_reg;
    logic [rsd_pkg::COLOR_W-1:0] hi_color_reg;
    logic [rsd_pkg::COLOR_W-1:0] lo_color_reg;

    logic                        pend_valid_reg;
    logic [rsd_pkg::ROW_W-1:0]   pend_row_reg;
    logic [rsd_pkg::X_W-1:0]     pend_x_reg;
    logic [rsd_pkg::LEN_W-1:0]   pend_len_reg;
    logic [rsd_pkg::COLOR_W-1:0] pend_c1_reg;
    logic [rsd_pkg::COLOR_W-1:0] pend_c2_reg;

    logic                        out_valid_reg;
    logic [rsd_pkg::OUT_W-1:0]   out_data_reg;
    logic                        out_last_reg;
    logic                        out_done_reg;

    logic [3:0]                  hi_idx;
    logic [3:0]                  lo_idx;
    logic [rsd_pkg::COLOR_W-1:0] hi_color;
    logic [rsd_pkg::COLOR_W-1:0] lo_color;
    logic [8:0]                  win_lo;
    logic [8:0]                  win_hi;
    logic [8:0]                  col9;
    logic [7:0]                  pairs_left;
    logic [7:0]                  take;
    logic [8:0]                  col_adv;
    logic [8:0]                  span_end;
    logic [8:0]                  vs;
    logic [8:0]                  ve;
    logic [8:0]                  x_off;
    logic [rsd_pkg::X_W-1:0]     span_x;
    logic [8:0]                  row_inc;
    logic                        row_wrap;
    logic                        out_free;

    // palette lookup, four colors per config word
    assign hi_idx   = s_tdata[15:12];
    assign lo_idx   = s_tdata[11:8];
    assign hi_color = palette_reg[hi_idx[3:2]][{hi_idx[1:0], 4'd0} +: rsd_pkg::COLOR_W];
    assign lo_color = palette_reg[lo_idx[3:2]][{lo_idx[1:0], 4'd0} +: rsd_pkg::COLOR_W];

    // visible window, clamped to the sprite width
    always_comb
    begin
        win_lo = {1'b0, clip_offset_reg};
        if (win_lo > WIDTH9)
        begin
            win_lo = WIDTH9;
        end
        win_hi = {1'b0, clip_offset_reg} + {1'b0, visible_width_reg};
        if (win_hi > WIDTH9)
        begin
            win_hi = WIDTH9;
        end
    end

    // one row piece of the current run
    always_comb
    begin
        col9       = {1'b0, col_reg};
        pairs_left = 8'((WIDTH9 - col9 + 9'd1) >> 1);
        take       = (rem_reg < pairs_left) ? rem_reg : pairs_left;
        col_adv    = col9 + {take, 1'b0};
        span_end   = (col_adv > WIDTH9) ? WIDTH9 : col_adv;
        vs         = (col9 > win_lo) ? col9 : win_lo;
        ve         = (span_end < win_hi) ? span_end : win_hi;
        x_off      = vs - win_lo;
        span_x     = dest_x_reg + {1'b0, x_off};
        row_inc    = {1'b0, row_reg} + 9'd1;
        row_wrap   = col_adv >= WIDTH9;
    end

    assign out_free      = !out_valid_reg || m_tready;
    assign st.more       = (rem_reg != 8'd0) && !fin_reg;
    assign st.hit        = vs < ve;
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = out_free;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_offset_reg   <= '0;
            visible_width_reg <= rsd_pkg::VISIBLE_WIDTH_RESET;
            dest_x_reg        <= '0;
            palette_reg[0]    <= '0;
            palette_reg[1]    <= '0;
            palette_reg[2]    <= '0;
            palette_reg[3]    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rsd_pkg::CFG_CLIP_OFFSET:      clip_offset_reg   <= cfg_data[7:0];
                rsd_pkg::CFG_VISIBLE_WIDTH:    visible_width_reg <= cfg_data[7:0];
                rsd_pkg::CFG_DEST_X:           dest_x_reg        <= cfg_data[9:0];
                rsd_pkg::CFG_PALETTE_LOW:      palette_reg[0]    <= cfg_data;
                rsd_pkg::CFG_PALETTE_MID_LOW:  palette_reg[1]    <= cfg_data;
                rsd_pkg::CFG_PALETTE_MID_HIGH: palette_reg[2]    <= cfg_data;
                rsd_pkg::CFG_PALETTE_HIGH:     palette_reg[3]    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // position and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            fin_reg        <= 1'b0;
            rem_reg        <= '0;
            done_now_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rem_reg      <= s_tdata[7:0];
                done_now_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                rem_reg <= rem_reg - take;
                if (row_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_inc[7:0];
                    if (row_inc >= HEIGHT9)
                    begin
                        fin_reg      <= 1'b1;
                        done_now_reg <= 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_adv[7:0];
                end
            end

            if (cmd.capture)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.push)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hi_color_reg <= hi_color;
            lo_color_reg <= lo_color;
        end
        if (cmd.capture)
        begin
            pend_row_reg <= row_reg;
            pend_x_reg   <= span_x;
            pend_len_reg <= 8'(ve - vs);
            pend_c1_reg  <= vs[0] ? lo_color_reg : hi_color_reg;
            pend_c2_reg  <= vs[0] ? hi_color_reg : lo_color_reg;
        end
        if (cmd.push)
        begin
            out_data_reg <= {6'd0, pend_c2_reg, pend_c1_reg, pend_len_reg,
                             pend_x_reg, pend_row_reg};
            out_last_reg <= cmd.last;
            out_done_reg <= cmd.last && done_now_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

// File: hw/rtl/rle_nibble_sprite_span_decoder.sv
// run-length decoder for a 4-bit palette sprite, emitting clipped row spans
// s_tdata carries one run: repeat count and a pixel pair (two palette indices,
// high nibble on the left). m_tdata carries one span per item: row, screen x,
// length and the two alternating colors; m_tlast marks the final span of a
// run, m_tuser marks the span that completes the last sprite row.
// config: cfg_we with cfg_index selects clip offset, visible width, dest x
// and the four palette words; write only while no run is in flight.
// flow: a run is accepted only in idle and walks the row pieces it covers in
// the piece loop (one piece per cycle while no visible piece waits for room at
// the output), then closes through flush before idle takes the next run.
// each span sits in a pending register until the next visible piece shows
// whether it is the last one; from there it is pushed into the output register
// that drives m_tvalid. a new run is not taken before the last one has been
// flushed and the block is back in idle.
// reset clears position, row, done flag and config to defaults; once the last
// row completes, every further run is taken and dropped. when m_tready is low
// the output register holds its span and the piece loop waits for room.
module rle_nibble_sprite_span_decoder
#(
    parameter int SPRITE_WIDTH  = 132,
    parameter int SPRITE_HEIGHT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // run_count, pixel_pair
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // row_index, screen_x, span_length, first_color, second_color
    output logic        m_tlast,
    output logic        m_tuser    // image_done
);

    rsd_pkg::cmd_t    cmd;
    rsd_pkg::status_t st;

    rsd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rsd_datapath
    #(
        .SPRITE_WIDTH  (SPRITE_WIDTH),
        .SPRITE_HEIGHT (SPRITE_HEIGHT)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// File: hw/rtl/rsd_checker.sv
module rsd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // done only on the closing span of a run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("done flag without last");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[25:18] != 8'd0)
        else $error("empty span");

    // one run at a time
    a_one_run: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a run is in flight");

endmodule

bind rle_nibble_sprite_span_decoder rsd_checker u_rsd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
